FILE: rtl/multi_detector_flat_field_correct_macros.svh
// ----------------------------------------------------------------------------
// multi detector flat field correction: assertion macros
// clocked on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef MULTI_DETECTOR_FLAT_FIELD_CORRECT_MACROS_SVH
`define MULTI_DETECTOR_FLAT_FIELD_CORRECT_MACROS_SVH

// same-cycle implication
`define MDFFC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MDFFC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/mdffc_pkg.sv
// ----------------------------------------------------------------------------
// mdffc_pkg
// shared codes, widths and pipeline record for the flat field corrector
// ----------------------------------------------------------------------------
package mdffc_pkg;

    localparam int IDX_W     = 24;
    localparam int ACC_W     = 32;
    localparam int PIX_W     = 16;
    localparam int NUM_W     = 33;
    localparam int DEN_W     = 16;
    localparam int DET_SLOTS = 4;

    localparam logic [2:0] KIND_LOAD_OFF  = 3'd0;
    localparam logic [2:0] KIND_LOAD_GAIN = 3'd1;
    localparam logic [2:0] KIND_LOAD_BASE = 3'd2;
    localparam logic [2:0] KIND_LOAD_NORM = 3'd3;
    localparam logic [2:0] KIND_DARK      = 3'd4;
    localparam logic [2:0] KIND_BRIGHT    = 3'd5;
    localparam logic [2:0] KIND_CORRECT   = 3'd6;
    localparam logic [2:0] OP_NONE        = 3'd7;

    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_SKIP   = 2'd1;
    localparam logic [1:0] ST_REJECT = 2'd2;

    localparam logic [2:0] CFG_OFFSET_EN     = 3'd0;
    localparam logic [2:0] CFG_GAIN_EN       = 3'd1;
    localparam logic [2:0] CFG_BASELINE_EN   = 3'd2;
    localparam logic [2:0] CFG_TARGET_LEVEL  = 3'd3;
    localparam logic [2:0] CFG_PIXEL_DEPTH   = 3'd4;
    localparam logic [2:0] CFG_ACTIVE_MASK   = 3'd5;
    localparam logic [2:0] CFG_DARK_COUNT    = 3'd6;
    localparam logic [2:0] CFG_BRIGHT_TARGET = 3'd7;

    typedef struct packed {
        logic [PIX_W-1:0] offset;
        logic [PIX_W-1:0] gain;
        logic [PIX_W-1:0] baseline;
    } tab_word_t;

    typedef struct packed {
        logic [2:0]       op;
        logic [1:0]       status;
        logic             last;
        logic             nodiv;
        logic [IDX_W-1:0] idx;
        tab_word_t        tab;
        logic [ACC_W-1:0] acc;
    } meta_t;

    function automatic logic op_writes(input logic [2:0] op);
        logic w;
        w = 1'b0;
        case (op) inside
            KIND_LOAD_OFF, KIND_LOAD_GAIN, KIND_LOAD_BASE, KIND_DARK, KIND_BRIGHT: w = 1'b1;
            default: w = 1'b0;
        endcase
        return w;
    endfunction

endpackage

FILE: rtl/mdffc_store.sv
// ----------------------------------------------------------------------------
// mdffc_store
// per-pixel table memory and dark accumulator memory, registered reads
// ----------------------------------------------------------------------------
module mdffc_store
    import mdffc_pkg::*;
#(
    parameter int DEPTH = 262144,
    parameter int AW    = 18
) (
    input  logic             clk,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output tab_word_t        rd_tab,
    output logic [ACC_W-1:0] rd_acc,
    input  logic             tab_we,
    input  logic [AW-1:0]    tab_waddr,
    input  tab_word_t        tab_wdata,
    input  logic             acc_we,
    input  logic [AW-1:0]    acc_waddr,
    input  logic [ACC_W-1:0] acc_wdata
);

    tab_word_t        tab_mem [DEPTH];
    logic [ACC_W-1:0] acc_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (tab_we)
        begin
            tab_mem[tab_waddr] <= tab_wdata;
        end
        if (rd_en)
        begin
            rd_tab <= tab_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc_we)
        begin
            acc_mem[acc_waddr] <= acc_wdata;
        end
        if (rd_en)
        begin
            rd_acc <= acc_mem[rd_addr];
        end
    end

endmodule

FILE: rtl/mdffc_div.sv
// ----------------------------------------------------------------------------
// mdffc_div
// pipelined restoring divider, one quotient bit per stage, carries a record
// ----------------------------------------------------------------------------
module mdffc_div
    import mdffc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  meta_t            in_meta,
    input  logic [NUM_W-1:0] in_num,
    input  logic [DEN_W-1:0] in_den,
    output logic             stage_valid [NUM_W],
    output meta_t            stage_meta [NUM_W],
    output logic [NUM_W-1:0] quot
);

    logic [DEN_W-1:0] rem_reg   [NUM_W];
    logic [NUM_W-1:0] nq_reg    [NUM_W];
    logic [DEN_W-1:0] den_reg   [NUM_W];
    meta_t            meta_reg  [NUM_W];
    logic             valid_reg [NUM_W];

    for (genvar s = 0; s < NUM_W; s++)
    begin : g_step
        logic [DEN_W-1:0] rem_i;
        logic [NUM_W-1:0] nq_i;
        logic [DEN_W-1:0] den_i;
        meta_t            meta_i;
        logic             valid_i;
        logic [DEN_W:0]   trial;
        logic             take;

        if (s == 0)
        begin : g_first
            assign rem_i   = '0;
            assign nq_i    = in_num;
            assign den_i   = in_den;
            assign meta_i  = in_meta;
            assign valid_i = in_valid;
        end
        else
        begin : g_rest
            assign rem_i   = rem_reg[s-1];
            assign nq_i    = nq_reg[s-1];
            assign den_i   = den_reg[s-1];
            assign meta_i  = meta_reg[s-1];
            assign valid_i = valid_reg[s-1];
        end

        assign trial = {rem_i, nq_i[NUM_W-1]};
        assign take  = trial >= {1'b0, den_i};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s]  <= take ? DEN_W'(trial - {1'b0, den_i}) : trial[DEN_W-1:0];
                nq_reg[s]   <= {nq_i[NUM_W-2:0], take};
                den_reg[s]  <= den_i;
                meta_reg[s] <= meta_i;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[s] <= valid_i;
            end
        end

        assign stage_valid[s] = valid_reg[s];
        assign stage_meta[s]  = meta_reg[s];
    end

    assign quot = nq_reg[NUM_W-1];

endmodule

FILE: rtl/mdffc_corr.sv
// ----------------------------------------------------------------------------
// mdffc_corr
// offset, gain, normalization and baseline arithmetic with round and clamp
// ----------------------------------------------------------------------------
module mdffc_corr
    import mdffc_pkg::*;
#(
    parameter int GF  = 12,
    parameter int LAT = 33
) (
    input  logic             clk,
    input  logic             en,
    input  logic [PIX_W-1:0] sample,
    input  logic [PIX_W-1:0] offset,
    input  logic [PIX_W-1:0] gain,
    input  logic [PIX_W-1:0] baseline,
    input  logic [PIX_W-1:0] norm,
    input  logic             offset_enable,
    input  logic             gain_enable,
    input  logic             baseline_enable,
    input  logic [PIX_W-1:0] target_level,
    input  logic [4:0]       pixel_depth,
    output logic [PIX_W-1:0] value,
    output logic             clamped
);

    localparam int VW = (2*GF + 19 > 52) ? 2*GF + 19 : 52;
    localparam int RW = VW - 2*GF;

    logic signed [16:0]   diff;
    logic        [16:0]   gfac;
    logic signed [34:0]   p1_next;
    logic signed [34:0]   p1_reg;
    logic [PIX_W-1:0]     norm1_reg;
    logic [PIX_W-1:0]     base1_reg;
    logic [PIX_W-1:0]     base2_reg;
    logic signed [51:0]   p2_reg;
    logic signed [17:0]   offs;
    logic signed [VW-1:0] v3_next;
    logic signed [VW-1:0] v3_reg;
    logic [VW-1:0]        r_full;
    logic [RW-1:0]        r;
    logic [4:0]           dsat;
    logic [16:0]          maxv;
    logic [PIX_W-1:0]     val4;
    logic                 cl4;
    logic [PIX_W-1:0]     val_pipe [LAT-3];
    logic                 cl_pipe  [LAT-3];

    always_comb
    begin
        diff = $signed({1'b0, sample}) - (offset_enable ? $signed({1'b0, offset}) : 17'sd0);
        gfac = gain_enable ? {1'b0, gain} : 17'(32'd1 << GF);
        p1_next = diff * $signed({1'b0, gfac});
    end

    always_comb
    begin
        offs = $signed({2'b0, target_level})
             - (baseline_enable ? $signed({2'b0, base2_reg}) : 18'sd0);
        v3_next = VW'(p2_reg) + (VW'(offs) <<< (2*GF));
    end

    always_comb
    begin
        dsat   = (pixel_depth < 5'd8) ? 5'd8 : ((pixel_depth > 5'd16) ? 5'd16 : pixel_depth);
        maxv   = 17'((32'd1 << dsat) - 32'd1);
        r_full = VW'($unsigned(v3_reg) + (VW'(1) << (2*GF - 1)));
        r      = r_full[VW-1:2*GF];
        if (v3_reg < 0)
        begin
            val4 = '0;
            cl4  = 1'b1;
        end
        else if (r > RW'(maxv))
        begin
            val4 = maxv[PIX_W-1:0];
            cl4  = 1'b1;
        end
        else
        begin
            val4 = r[PIX_W-1:0];
            cl4  = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg      <= p1_next;
            norm1_reg   <= norm;
            base1_reg   <= baseline;
            p2_reg      <= p1_reg * $signed({1'b0, norm1_reg});
            base2_reg   <= base1_reg;
            v3_reg      <= v3_next;
            val_pipe[0] <= val4;
            cl_pipe[0]  <= cl4;
            for (int k = 1; k < LAT - 3; k++)
            begin
                val_pipe[k] <= val_pipe[k-1];
                cl_pipe[k]  <= cl_pipe[k-1];
            end
        end
    end

    assign value   = val_pipe[LAT-4];
    assign clamped = cl_pipe[LAT-4];

endmodule

FILE: rtl/multi_detector_flat_field_correct.sv
// ----------------------------------------------------------------------------
// multi_detector_flat_field_correct
// per-pixel offset/gain flat field correction for several detectors
// ----------------------------------------------------------------------------
//  channel  handshake             payload
//  cfg      cfg_we                cfg_index, cfg_data
//  in       in_valid / in_ready   kind, detector, pixel_index, sample, first/last_frame
//  out      out_valid / out_ready value, status, clamped
//
//  one beat per cycle while in_ready is high; path from input beat to output beat
//  (read stage, 33-stage divider for dark averages and bright gains, output register)
//  in_ready drops while an in-flight beat still has to write the same table entry
//  after reset a clearing pass over all DETECTORS*PIXELS_PER_DETECTOR entries
//  (262144 by default) holds in_ready low
//  a stalled output fills a skid register, then the whole pipeline holds
// ----------------------------------------------------------------------------
`include "multi_detector_flat_field_correct_macros.svh"

module multi_detector_flat_field_correct
    import mdffc_pkg::*;
#(
    parameter int DETECTORS           = 4,
    parameter int PIXELS_PER_DETECTOR = 65536,
    parameter int GAIN_FRAC_BITS      = 12
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  kind,
    input  logic [1:0]  detector,
    input  logic [15:0] pixel_index,
    input  logic [15:0] sample,
    input  logic        first_frame,
    input  logic        last_frame,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] value,
    output logic [1:0]  status,
    output logic        clamped
);

    localparam int DEPTH    = DETECTORS * PIXELS_PER_DETECTOR;
    localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int ONE      = ((1 << GAIN_FRAC_BITS) > 65535) ? 65535 : (1 << GAIN_FRAC_BITS);
    localparam int GMAX     = ((10 << GAIN_FRAC_BITS) > 65535) ? 65535 : (10 << GAIN_FRAC_BITS);
    localparam int GMIN     = ((1 << GAIN_FRAC_BITS) + 5) / 10;
    localparam int NORM_MAX = 10 << GAIN_FRAC_BITS;

    logic             offset_enable_reg;
    logic             gain_enable_reg;
    logic             baseline_enable_reg;
    logic [15:0]      target_level_reg;
    logic [4:0]       pixel_depth_reg;
    logic [3:0]       active_mask_reg;
    logic [15:0]      dark_count_reg;
    logic [15:0]      bright_target_reg;

    logic             clr_active_reg;
    logic [AW-1:0]    clr_addr_reg;

    logic [PIX_W-1:0] norm_reg [DET_SLOTS];

    logic             s1_valid_reg;
    logic [2:0]       s1_op_reg;
    logic [1:0]       s1_status_reg;
    logic [AW-1:0]    s1_idx_reg;
    logic [15:0]      s1_sample_reg;
    logic             s1_first_reg;
    logic             s1_last_reg;
    logic [PIX_W-1:0] s1_norm_reg;

    logic             out_valid_reg;
    logic [15:0]      out_value_reg;
    logic [1:0]       out_status_reg;
    logic             out_clamped_reg;
    logic             skid_valid_reg;
    logic [15:0]      skid_value_reg;
    logic [1:0]       skid_status_reg;
    logic             skid_clamped_reg;

    logic             en;
    logic             accept;
    logic             hazard;
    logic [AW-1:0]    in_idx;
    logic [2:0]       acc_op;
    logic [1:0]       acc_status;
    logic             norm_wr;

    tab_word_t        rd_tab;
    logic [ACC_W-1:0] rd_acc;

    logic [ACC_W-1:0] acc_new;
    logic [15:0]      dark_n;
    logic [16:0]      bdiff;
    logic [NUM_W-1:0] div_num;
    logic [DEN_W-1:0] div_den;
    meta_t            s1_meta;

    logic             stage_valid [NUM_W];
    meta_t            stage_meta  [NUM_W];
    logic [NUM_W-1:0] quot;
    logic [15:0]      corr_value;
    logic             corr_clamped;

    meta_t            meta_l;
    logic             tail_move;
    logic [15:0]      tail_value;
    logic             tail_clamped;
    tab_word_t        tail_tab;
    logic             tab_wr;
    logic             acc_wr;

    logic             mem_tab_we;
    logic [AW-1:0]    mem_tab_addr;
    tab_word_t        mem_tab_data;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_enable_reg   <= 1'b1;
            gain_enable_reg     <= 1'b1;
            baseline_enable_reg <= 1'b0;
            target_level_reg    <= 16'd0;
            pixel_depth_reg     <= 5'd14;
            active_mask_reg     <= 4'hf;
            dark_count_reg      <= 16'd1;
            bright_target_reg   <= 16'd8192;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_OFFSET_EN:     offset_enable_reg   <= cfg_data[0];
                CFG_GAIN_EN:       gain_enable_reg     <= cfg_data[0];
                CFG_BASELINE_EN:   baseline_enable_reg <= cfg_data[0];
                CFG_TARGET_LEVEL:  target_level_reg    <= cfg_data;
                CFG_PIXEL_DEPTH:   pixel_depth_reg     <= cfg_data[4:0];
                CFG_ACTIVE_MASK:   active_mask_reg     <= cfg_data[3:0];
                CFG_DARK_COUNT:    dark_count_reg      <= cfg_data;
                CFG_BRIGHT_TARGET: bright_target_reg   <= cfg_data;
            endcase
        end
    end

    // table clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else if (clr_active_reg)
        begin
            clr_addr_reg <= clr_addr_reg + AW'(1);
            if (clr_addr_reg == AW'(DEPTH - 1))
            begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    // input decode
    always_comb
    begin
        acc_op     = OP_NONE;
        acc_status = ST_DONE;
        norm_wr    = 1'b0;
        if (kind > KIND_CORRECT || 32'(detector) >= DETECTORS)
        begin
            acc_status = ST_REJECT;
        end
        else if (!active_mask_reg[detector])
        begin
            acc_status = ST_SKIP;
        end
        else if (kind == KIND_LOAD_NORM)
        begin
            if (sample == 16'd0 || 32'(sample) > NORM_MAX)
            begin
                acc_status = ST_REJECT;
            end
            else
            begin
                norm_wr = 1'b1;
            end
        end
        else if (32'(pixel_index) >= PIXELS_PER_DETECTOR)
        begin
            acc_status = ST_REJECT;
        end
        else if (kind == KIND_BRIGHT && bright_target_reg == 16'd0)
        begin
            acc_status = ST_REJECT;
        end
        else
        begin
            acc_op = kind;
        end
    end

    assign in_idx = AW'(detector) * AW'(PIXELS_PER_DETECTOR) + AW'(pixel_index);

    // read-modify-write interlock
    always_comb
    begin
        hazard = s1_valid_reg && op_writes(s1_op_reg) && (s1_idx_reg == in_idx);
        for (int s = 0; s < NUM_W; s++)
        begin
            if (stage_valid[s] && op_writes(stage_meta[s].op)
                && (stage_meta[s].idx[AW-1:0] == in_idx))
            begin
                hazard = 1'b1;
            end
        end
    end

    assign en       = !skid_valid_reg;
    assign in_ready = en && !clr_active_reg && !hazard;
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int d = 0; d < DET_SLOTS; d++)
            begin
                norm_reg[d] <= PIX_W'(ONE);
            end
        end
        else if (accept && norm_wr)
        begin
            norm_reg[detector] <= sample;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg     <= acc_op;
            s1_status_reg <= acc_status;
            s1_idx_reg    <= in_idx;
            s1_sample_reg <= sample;
            s1_first_reg  <= first_frame;
            s1_last_reg   <= last_frame;
            s1_norm_reg   <= norm_reg[detector];
        end
    end

    mdffc_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk       (clk),
        .rd_en     (accept),
        .rd_addr   (in_idx),
        .rd_tab    (rd_tab),
        .rd_acc    (rd_acc),
        .tab_we    (mem_tab_we),
        .tab_waddr (mem_tab_addr),
        .tab_wdata (mem_tab_data),
        .acc_we    (tail_move && acc_wr),
        .acc_waddr (meta_l.idx[AW-1:0]),
        .acc_wdata (meta_l.acc)
    );

    // operand stage
    always_comb
    begin
        acc_new = s1_first_reg ? {16'd0, s1_sample_reg} : rd_acc + {16'd0, s1_sample_reg};
        dark_n  = (dark_count_reg == 16'd0) ? 16'd1 : dark_count_reg;
        bdiff   = {1'b0, s1_sample_reg} - {1'b0, rd_tab.offset};
        div_num = '0;
        div_den = 16'd1;
        if (s1_op_reg == KIND_DARK)
        begin
            div_num = {1'b0, acc_new} + NUM_W'(dark_n >> 1);
            div_den = dark_n;
        end
        else if (s1_op_reg == KIND_BRIGHT)
        begin
            div_num = (NUM_W'(bright_target_reg) << GAIN_FRAC_BITS) + NUM_W'(bdiff[15:1]);
            div_den = bdiff[15:0];
        end
        s1_meta.op     = s1_op_reg;
        s1_meta.status = s1_status_reg;
        s1_meta.last   = s1_last_reg;
        s1_meta.nodiv  = bdiff[16] || (bdiff == 17'd0);
        s1_meta.idx    = IDX_W'(s1_idx_reg);
        s1_meta.tab    = rd_tab;
        s1_meta.acc    = (s1_op_reg == KIND_DARK) ? acc_new : {16'd0, s1_sample_reg};
    end

    mdffc_div u_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (s1_valid_reg),
        .in_meta     (s1_meta),
        .in_num      (div_num),
        .in_den      (div_den),
        .stage_valid (stage_valid),
        .stage_meta  (stage_meta),
        .quot        (quot)
    );

    mdffc_corr #(
        .GF  (GAIN_FRAC_BITS),
        .LAT (NUM_W)
    ) u_corr (
        .clk             (clk),
        .en              (en),
        .sample          (s1_sample_reg),
        .offset          (rd_tab.offset),
        .gain            (rd_tab.gain),
        .baseline        (rd_tab.baseline),
        .norm            (s1_norm_reg),
        .offset_enable   (offset_enable_reg),
        .gain_enable     (gain_enable_reg),
        .baseline_enable (baseline_enable_reg),
        .target_level    (target_level_reg),
        .pixel_depth     (pixel_depth_reg),
        .value           (corr_value),
        .clamped         (corr_clamped)
    );

    // result and write-back
    assign meta_l    = stage_meta[NUM_W-1];
    assign tail_move = en && stage_valid[NUM_W-1];

    always_comb
    begin
        tail_tab     = meta_l.tab;
        tail_value   = '0;
        tail_clamped = 1'b0;
        tab_wr       = 1'b0;
        acc_wr       = 1'b0;
        case (meta_l.op)
            KIND_LOAD_OFF:
            begin
                tail_tab.offset = meta_l.acc[PIX_W-1:0];
                tab_wr          = 1'b1;
            end
            KIND_LOAD_GAIN:
            begin
                tail_tab.gain = meta_l.acc[PIX_W-1:0];
                tab_wr        = 1'b1;
            end
            KIND_LOAD_BASE:
            begin
                tail_tab.baseline = meta_l.acc[PIX_W-1:0];
                tab_wr            = 1'b1;
            end
            KIND_DARK:
            begin
                acc_wr = 1'b1;
                if (meta_l.last)
                begin
                    if (|quot[NUM_W-1:PIX_W])
                    begin
                        tail_value   = '1;
                        tail_clamped = 1'b1;
                    end
                    else
                    begin
                        tail_value = quot[PIX_W-1:0];
                    end
                    tail_tab.offset = tail_value;
                    tab_wr          = 1'b1;
                end
            end
            KIND_BRIGHT:
            begin
                if (meta_l.nodiv)
                begin
                    tail_value = PIX_W'(ONE);
                end
                else if (quot < NUM_W'(GMIN))
                begin
                    tail_value   = PIX_W'(GMIN);
                    tail_clamped = 1'b1;
                end
                else if (quot > NUM_W'(GMAX))
                begin
                    tail_value   = PIX_W'(GMAX);
                    tail_clamped = 1'b1;
                end
                else
                begin
                    tail_value = quot[PIX_W-1:0];
                end
                tail_tab.gain = tail_value;
                tab_wr        = 1'b1;
            end
            KIND_CORRECT:
            begin
                tail_value   = corr_value;
                tail_clamped = corr_clamped;
            end
            default:
            begin
                tail_value = '0;
            end
        endcase
    end

    always_comb
    begin
        if (clr_active_reg)
        begin
            mem_tab_we            = 1'b1;
            mem_tab_addr          = clr_addr_reg;
            mem_tab_data.offset   = '0;
            mem_tab_data.gain     = PIX_W'(ONE);
            mem_tab_data.baseline = '0;
        end
        else
        begin
            mem_tab_we   = tail_move && tab_wr;
            mem_tab_addr = meta_l.idx[AW-1:0];
            mem_tab_data = tail_tab;
        end
    end

    // output register with skid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= tail_move;
            end
        end
        else if (tail_move)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_value_reg   <= skid_value_reg;
                out_status_reg  <= skid_status_reg;
                out_clamped_reg <= skid_clamped_reg;
            end
            else
            begin
                out_value_reg   <= tail_value;
                out_status_reg  <= meta_l.status;
                out_clamped_reg <= tail_clamped;
            end
        end
        else if (tail_move)
        begin
            skid_value_reg   <= tail_value;
            skid_status_reg  <= meta_l.status;
            skid_clamped_reg <= tail_clamped;
        end
    end

    assign out_valid = out_valid_reg;
    assign value     = out_value_reg;
    assign status    = out_status_reg;
    assign clamped   = out_clamped_reg;

    `MDFFC_ASSERT_NOW(a_no_beat_in_clear, clr_active_reg, !in_ready, "input beat during clearing pass")
    `MDFFC_ASSERT_NOW(a_no_tail_in_clear, clr_active_reg, !tail_move, "pipeline busy during clearing pass")
    `MDFFC_ASSERT_NOW(a_skid_behind_out, skid_valid_reg, out_valid_reg, "skid full with output empty")
    `MDFFC_ASSERT_NEXT(a_skid_drains, skid_valid_reg && out_ready, !skid_valid_reg, "skid not drained")

endmodule
